// File: rtl/ihpa_pkg.sv
// Shared types, codes and helpers for the Intel HEX page assembler.
`default_nettype none

package ihpa_pkg;

  localparam int PAGE_BYTES_DEF = 64;

  // Result queue: an item is taken only while at most FIFO_ACCEPT_MAX entries are held,
  // so the two results of one item always fit.
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_ACCEPT_MAX = FIFO_DEPTH - 2;
  localparam int FIFO_PW         = $clog2(FIFO_DEPTH);
  localparam int FIFO_LW         = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  localparam logic [7:0] REC_DATA    = 8'h00;
  localparam logic [7:0] REC_EOF     = 8'h01;
  localparam logic [7:0] REC_EXT_LIN = 8'h04;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_CLOSE  = 2'd1,
    KIND_ACCEPT = 2'd2,
    KIND_REJECT = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    PH_START  = 4'd0,
    PH_LEN_H  = 4'd1,
    PH_LEN_L  = 4'd2,
    PH_OFF0   = 4'd3,
    PH_OFF1   = 4'd4,
    PH_OFF2   = 4'd5,
    PH_OFF3   = 4'd6,
    PH_TYPE_H = 4'd7,
    PH_TYPE_L = 4'd8,
    PH_DATA_H = 4'd9,
    PH_DATA_L = 4'd10,
    PH_TAIL   = 4'd11
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [30:0] word_address;
    logic [6:0]  page_bytes;
    logic        last;
  } result_t;

  // Results of one item: up to two, in order.
  typedef struct packed {
    result_t    r0;
    result_t    r1;
    logic [1:0] count;
  } push_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.valid = 1'b1;
    if (c inside {[8'h30:8'h39]}) begin
      h.value = 4'(c - 8'h30);
    end else if (c inside {[8'h41:8'h46]}) begin
      h.value = 4'(c - 8'h37);
    end else if (c inside {[8'h61:8'h66]}) begin
      h.value = 4'(c - 8'h57);
    end else begin
      h.valid = 1'b0;
      h.value = 4'd0;
    end
    return h;
  endfunction

  function automatic result_t mk_result(input kind_t k, input logic [7:0] b,
                                        input logic [30:0] a, input logic [6:0] f);
    result_t r;
    r.kind         = k;
    r.data_byte    = b;
    r.word_address = a;
    r.page_bytes   = f;
    r.last         = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/intel_hex_page_assembler.sv
// Top level of the Intel HEX page assembler: parser plus result queue.
// Usage:
//   Input channel (in_valid / in_stall): one text character per item, or an
//   end_of_input marker that finishes the open line and flushes the open page.
//   Output channel (out_valid / out_stall): one result per item - data byte,
//   page closed, line accepted or line rejected - with the page word address
//   and fill. last marks the final result caused by one input item.
// Latency: results of an item join the result queue the cycle after it is taken.
// Throughput: one character per cycle while each item yields at most one
//   result and out_stall is low. Items yielding two results (page close after
//   a byte, end-of-file record with an open page, end of input on an open
//   line with an open page) hold the output longer; the four-entry result
//   queue absorbs this and in_stall rises only when more than two are held.
// Reset: rst is synchronous; it returns the parser to line start, empties the
//   page and the queue, and clears the upper linear base.
// Stall: when out_stall holds, the head result stays put and the queue fills;
//   in_stall then holds the input side until room for two results returns.
`default_nettype none

module intel_hex_page_assembler #(
  parameter int PAGE_BYTES = ihpa_pkg::PAGE_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  character,
  input  wire logic        end_of_input,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [7:0]       data_byte,
  output logic [30:0]      word_address,
  output logic [6:0]       page_bytes,
  output logic             last
);

  localparam int LW = ihpa_pkg::FIFO_LW;

  logic                    accept;
  logic                    pop;
  ihpa_pkg::push_t         push;
  ihpa_pkg::result_t       head;
  logic [LW-1:0]           level;

  // stall depends only on queue level, never on out_stall
  assign in_stall  = (level > LW'(ihpa_pkg::FIFO_ACCEPT_MAX));
  assign accept    = in_valid && !in_stall;
  assign out_valid = (level != '0);
  assign pop       = out_valid && !out_stall;

  ihpa_parser #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .character    (character),
    .end_of_input (end_of_input),
    .push         (push)
  );

  ihpa_result_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push_en (accept),
    .push    (push),
    .pop     (pop),
    .head    (head),
    .level   (level)
  );

  assign kind         = head.kind;
  assign data_byte    = head.data_byte;
  assign word_address = head.word_address;
  assign page_bytes   = head.page_bytes;
  assign last         = head.last;

  // A newline always finishes a line, so a result must be waiting next cycle.
  a_newline_result: assert property (@(posedge clk) disable iff (rst)
    (accept && !end_of_input && character == ihpa_pkg::CHAR_LF) |=> out_valid)
    else $error("newline item produced no result");

  // Queue never holds more than its depth.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    level <= LW'(ihpa_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  // Reset empties the output side.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("results visible after reset");

endmodule

`default_nettype wire

// File: rtl/ihpa_parser.sv
// Line parser and page tracker: one character per cycle on accept, up to two results per item.
`default_nettype none

module ihpa_parser #(
  parameter int PAGE_BYTES = ihpa_pkg::PAGE_BYTES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         accept,
  input  wire logic [7:0]   character,
  input  wire logic         end_of_input,
  output ihpa_pkg::push_t   push
);

  localparam int FW = $clog2(PAGE_BYTES + 1);
  localparam logic [FW-1:0] FULL = FW'(PAGE_BYTES);

  ihpa_pkg::phase_t phase, phase_next;
  logic [3:0]    high_nibble, high_nibble_next;
  logic [7:0]    record_length, record_length_next;
  logic [15:0]   record_offset, record_offset_next;
  logic [7:0]    record_kind, record_kind_next;
  logic [7:0]    bytes_done, bytes_done_next;
  logic [15:0]   upper_base, upper_base_next;
  logic [30:0]   page_start, page_start_next;
  logic [FW-1:0] page_fill, page_fill_next;
  logic          line_bad, line_bad_next;

  ihpa_pkg::hex_t hv;
  logic [7:0]     bd_inc;
  logic           finish;
  logic           digit_step;

  function automatic logic [6:0] fill7(input logic [FW-1:0] f);
    logic [8:0] e;
    e = 9'(f);
    return e[6:0];
  endfunction

  assign hv     = ihpa_pkg::hex_decode(character);
  assign bd_inc = bytes_done + 8'd1;
  assign finish = end_of_input ? (phase != ihpa_pkg::PH_START || line_bad)
                               : (character == ihpa_pkg::CHAR_LF);
  assign digit_step = !end_of_input && character != ihpa_pkg::CHAR_CR &&
                      character != ihpa_pkg::CHAR_LF && phase != ihpa_pkg::PH_START &&
                      phase != ihpa_pkg::PH_TAIL && !line_bad && hv.valid;

  // Next phase and bad-line flag
  always_comb begin
    phase_next    = phase;
    line_bad_next = line_bad;
    if (finish) begin
      phase_next    = ihpa_pkg::PH_START;
      line_bad_next = 1'b0;
    end else if (end_of_input || character == ihpa_pkg::CHAR_CR) begin
      phase_next = phase;
    end else if (phase == ihpa_pkg::PH_START) begin
      if (character == ihpa_pkg::CHAR_COLON) begin
        phase_next = ihpa_pkg::PH_LEN_H;
      end else begin
        line_bad_next = 1'b1;
        phase_next    = ihpa_pkg::PH_TAIL;
      end
    end else if (!line_bad && phase != ihpa_pkg::PH_TAIL) begin
      if (!hv.valid) begin
        line_bad_next = 1'b1;
      end else begin
        case (phase)
          ihpa_pkg::PH_LEN_H:  phase_next = ihpa_pkg::PH_LEN_L;
          ihpa_pkg::PH_LEN_L:  phase_next = ihpa_pkg::PH_OFF0;
          ihpa_pkg::PH_OFF0:   phase_next = ihpa_pkg::PH_OFF1;
          ihpa_pkg::PH_OFF1:   phase_next = ihpa_pkg::PH_OFF2;
          ihpa_pkg::PH_OFF2:   phase_next = ihpa_pkg::PH_OFF3;
          ihpa_pkg::PH_OFF3:   phase_next = ihpa_pkg::PH_TYPE_H;
          ihpa_pkg::PH_TYPE_H: phase_next = ihpa_pkg::PH_TYPE_L;
          ihpa_pkg::PH_TYPE_L: phase_next = (record_length == 8'd0) ? ihpa_pkg::PH_TAIL
                                                                    : ihpa_pkg::PH_DATA_H;
          ihpa_pkg::PH_DATA_H: phase_next = ihpa_pkg::PH_DATA_L;
          ihpa_pkg::PH_DATA_L: phase_next = (bd_inc >= record_length) ? ihpa_pkg::PH_TAIL
                                                                      : ihpa_pkg::PH_DATA_H;
          default:             phase_next = ihpa_pkg::PH_START;
        endcase
      end
    end
  end

  // Datapath and results
  always_comb begin
    ihpa_pkg::result_t slot [2];
    logic [1:0]    n;
    logic [FW-1:0] fill_v;
    logic [30:0]   ps_v;
    logic [7:0]    byte_v;
    logic [15:0]   sum;

    high_nibble_next   = high_nibble;
    record_length_next = record_length;
    record_offset_next = record_offset;
    record_kind_next   = record_kind;
    bytes_done_next    = bytes_done;
    upper_base_next    = upper_base;
    fill_v   = page_fill;
    ps_v     = page_start;
    n        = 2'd0;
    byte_v   = {high_nibble, hv.value};
    sum      = record_offset + {8'd0, bytes_done};
    slot[0]  = ihpa_pkg::mk_result(ihpa_pkg::KIND_DATA, 8'd0, 31'd0, 7'd0);
    slot[1]  = slot[0];

    if (finish) begin
      if (!line_bad && phase == ihpa_pkg::PH_TAIL) begin
        if (record_kind == ihpa_pkg::REC_EOF && fill_v != '0) begin
          slot[n[0]] = ihpa_pkg::mk_result(ihpa_pkg::KIND_CLOSE, 8'd0, ps_v, fill7(fill_v));
          n = n + 2'd1;
          fill_v = '0;
        end
        slot[n[0]] = ihpa_pkg::mk_result(ihpa_pkg::KIND_ACCEPT, 8'd0, ps_v, fill7(fill_v));
        n = n + 2'd1;
      end else begin
        slot[n[0]] = ihpa_pkg::mk_result(ihpa_pkg::KIND_REJECT, 8'd0, ps_v, fill7(fill_v));
        n = n + 2'd1;
      end
    end

    if (end_of_input && fill_v != '0) begin
      slot[n[0]] = ihpa_pkg::mk_result(ihpa_pkg::KIND_CLOSE, 8'd0, ps_v, fill7(fill_v));
      n = n + 2'd1;
      fill_v = '0;
    end

    if (digit_step) begin
      case (phase)
        ihpa_pkg::PH_LEN_H, ihpa_pkg::PH_TYPE_H, ihpa_pkg::PH_DATA_H: begin
          high_nibble_next = hv.value;
        end
        ihpa_pkg::PH_LEN_L: begin
          record_length_next = byte_v;
          record_offset_next = 16'd0;
        end
        ihpa_pkg::PH_OFF0, ihpa_pkg::PH_OFF1, ihpa_pkg::PH_OFF2, ihpa_pkg::PH_OFF3: begin
          record_offset_next = {record_offset[11:0], hv.value};
        end
        ihpa_pkg::PH_TYPE_L: begin
          record_kind_next = byte_v;
          bytes_done_next  = 8'd0;
        end
        ihpa_pkg::PH_DATA_L: begin
          if (record_kind == ihpa_pkg::REC_DATA) begin
            // page address latched by its first byte
            if (fill_v == '0) begin
              ps_v = {upper_base, sum[15:1]};
            end
            fill_v = fill_v + FW'(1);
            slot[n[0]] = ihpa_pkg::mk_result(ihpa_pkg::KIND_DATA, byte_v, ps_v, fill7(fill_v));
            n = n + 2'd1;
            if (fill_v >= FULL) begin
              slot[n[0]] = ihpa_pkg::mk_result(ihpa_pkg::KIND_CLOSE, 8'd0, ps_v,
                                               fill7(fill_v));
              n = n + 2'd1;
              fill_v = '0;
            end
          end else if (record_kind == ihpa_pkg::REC_EXT_LIN) begin
            if (bytes_done == 8'd0) begin
              record_offset_next = {8'd0, byte_v};
            end else if (bytes_done == 8'd1) begin
              upper_base_next = {record_offset[7:0], byte_v};
            end
          end
          bytes_done_next = bd_inc;
        end
        default: ;
      endcase
    end

    if (n == 2'd1) begin
      slot[0].last = 1'b1;
    end else if (n == 2'd2) begin
      slot[1].last = 1'b1;
    end

    page_fill_next  = fill_v;
    page_start_next = ps_v;
    push.r0    = slot[0];
    push.r1    = slot[1];
    push.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= ihpa_pkg::PH_START;
      high_nibble   <= 4'd0;
      record_length <= 8'd0;
      record_offset <= 16'd0;
      record_kind   <= 8'd0;
      bytes_done    <= 8'd0;
      upper_base    <= 16'd0;
      page_start    <= 31'd0;
      page_fill     <= '0;
      line_bad      <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      high_nibble   <= high_nibble_next;
      record_length <= record_length_next;
      record_offset <= record_offset_next;
      record_kind   <= record_kind_next;
      bytes_done    <= bytes_done_next;
      upper_base    <= upper_base_next;
      page_start    <= page_start_next;
      page_fill     <= page_fill_next;
      line_bad      <= line_bad_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ihpa_result_fifo.sv
// Result queue: takes up to two results per cycle, hands out one.
`default_nettype none

module ihpa_result_fifo (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push_en,
  input  wire ihpa_pkg::push_t                 push,
  input  wire logic                            pop,
  output ihpa_pkg::result_t                    head,
  output logic [ihpa_pkg::FIFO_LW-1:0]         level
);

  localparam int PW = ihpa_pkg::FIFO_PW;
  localparam int LW = ihpa_pkg::FIFO_LW;

  ihpa_pkg::result_t entries [ihpa_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr, wr_ptr1;
  logic [1:0]    pushn;

  assign pushn   = push_en ? push.count : 2'd0;
  assign wr_ptr1 = wr_ptr + PW'(1);
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    for (int i = 0; i < ihpa_pkg::FIFO_DEPTH; i++) begin
      if (pushn != 2'd0 && wr_ptr == PW'(i)) begin
        entries[i] <= push.r0;
      end
      if (pushn == 2'd2 && wr_ptr1 == PW'(i)) begin
        entries[i] <= push.r1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(pushn);
      rd_ptr <= rd_ptr + PW'(pop);
      level  <= level + LW'(pushn) - LW'(pop);
    end
  end

endmodule

`default_nettype wire

// File: test/intel_hex_page_assembler_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Intel HEX page assembler: HEX text stimulus, scoreboard.

module intel_hex_page_assembler_test;

  // Record type that the block only parses and skips (extended segment address).
  localparam logic [7:0] REC_EXT_SEG = 8'h02;

  // Random text items after the directed lines, spread over several idling profiles.
  localparam int TEXT_ITEMS  = 1950;
  localparam int NUM_PHASES  = 5;
  // Cycles with no handshake on either side before the run is declared hung.
  // Sender gaps and receiver stall runs both come from pick_gap.
  localparam int QUIET_LIMIT = 2000;
  // Cycles left for stray results once nothing more is expected.
  localparam int DRAIN_CYCLES = 10;

  // Tracks the parser state for every accepted item and holds the results
  // that item must produce, oldest first.
  class page_scoreboard;
    localparam int PAGE_LIMIT   = ihpa_pkg::PAGE_BYTES_DEF;
    localparam int SHOWN_ERRORS = 40;

    ihpa_pkg::result_t expected_q[$];
    int unsigned       errors;

    ihpa_pkg::phase_t phase;
    logic [3:0]  hi_digit;
    logic [7:0]  len;
    logic [15:0] offset;
    logic [7:0]  rtype;
    logic [7:0]  taken;
    logic [15:0] ela_base;
    logic [30:0] page_word;
    int          fill;
    bit          line_err;

    function new();
      errors    = 0;
      phase     = ihpa_pkg::PH_START;
      hi_digit  = '0;
      len       = '0;
      offset    = '0;
      rtype     = '0;
      taken     = '0;
      ela_base  = '0;
      page_word = '0;
      fill      = 0;
      line_err  = 1'b0;
    endfunction

    static function int digit_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      return -1;
    endfunction

    function void expect_result(ihpa_pkg::kind_t k, logic [7:0] b);
      ihpa_pkg::result_t r;
      r.kind         = k;
      r.data_byte    = b;
      r.word_address = page_word;
      r.page_bytes   = fill[6:0];
      r.last         = 1'b0;
      expected_q.push_back(r);
    endfunction

    function void end_line();
      if (!line_err && phase == ihpa_pkg::PH_TAIL) begin
        // EOF record closes an open page ahead of the accept
        if (rtype == ihpa_pkg::REC_EOF && fill > 0) begin
          expect_result(ihpa_pkg::KIND_CLOSE, 8'h00);
          fill = 0;
        end
        expect_result(ihpa_pkg::KIND_ACCEPT, 8'h00);
      end else begin
        expect_result(ihpa_pkg::KIND_REJECT, 8'h00);
      end
      phase    = ihpa_pkg::PH_START;
      line_err = 1'b0;
    endfunction

    function void take_byte(logic [7:0] b);
      logic [15:0] at;
      at = offset + 16'(taken);
      if (rtype == ihpa_pkg::REC_DATA) begin
        // page address latched on its first byte; offset wraps in 16 bits
        if (fill == 0) page_word = {ela_base, at[15:1]};
        fill++;
        expect_result(ihpa_pkg::KIND_DATA, b);
        if (fill >= PAGE_LIMIT) begin
          expect_result(ihpa_pkg::KIND_CLOSE, 8'h00);
          fill = 0;
        end
      end else if (rtype == ihpa_pkg::REC_EXT_LIN) begin
        if (taken == 8'd0) offset = {8'h00, b};
        else if (taken == 8'd1) ela_base = {offset[7:0], b};
      end
      taken++;
      phase = (taken >= len) ? ihpa_pkg::PH_TAIL : ihpa_pkg::PH_DATA_H;
    endfunction

    function void note_item(logic [7:0] c, logic eoi);
      int                first;
      int                v;
      ihpa_pkg::result_t r;
      first = expected_q.size();
      if (eoi) begin
        if (phase != ihpa_pkg::PH_START || line_err) end_line();
        if (fill > 0) begin
          expect_result(ihpa_pkg::KIND_CLOSE, 8'h00);
          fill = 0;
        end
      end else if (c == ihpa_pkg::CHAR_CR) begin
        // ignored
      end else if (c == ihpa_pkg::CHAR_LF) begin
        end_line();
      end else if (phase == ihpa_pkg::PH_START) begin
        if (c == ihpa_pkg::CHAR_COLON) begin
          phase = ihpa_pkg::PH_LEN_H;
        end else begin
          line_err = 1'b1;
          phase    = ihpa_pkg::PH_TAIL;
        end
      end else if (!line_err && phase != ihpa_pkg::PH_TAIL) begin
        v = digit_of(c);
        if (v < 0) begin
          line_err = 1'b1;
        end else begin
          case (phase)
            ihpa_pkg::PH_LEN_H, ihpa_pkg::PH_TYPE_H, ihpa_pkg::PH_DATA_H: begin
              hi_digit = v[3:0];
              phase    = ihpa_pkg::phase_t'(phase + 1);
            end
            ihpa_pkg::PH_LEN_L: begin
              len    = {hi_digit, v[3:0]};
              offset = '0;
              phase  = ihpa_pkg::PH_OFF0;
            end
            ihpa_pkg::PH_OFF0, ihpa_pkg::PH_OFF1, ihpa_pkg::PH_OFF2, ihpa_pkg::PH_OFF3: begin
              offset = {offset[11:0], v[3:0]};
              phase  = ihpa_pkg::phase_t'(phase + 1);
            end
            ihpa_pkg::PH_TYPE_L: begin
              rtype = {hi_digit, v[3:0]};
              taken = '0;
              phase = (len == 8'd0) ? ihpa_pkg::PH_TAIL : ihpa_pkg::PH_DATA_H;
            end
            ihpa_pkg::PH_DATA_L: begin
              take_byte({hi_digit, v[3:0]});
            end
            default: begin
              phase = ihpa_pkg::PH_START;
            end
          endcase
        end
      end
      if (expected_q.size() > first) begin
        r      = expected_q.pop_back();
        r.last = 1'b1;
        expected_q.push_back(r);
      end
    endfunction

    task report(string msg);
      if (errors < SHOWN_ERRORS) $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(ihpa_pkg::result_t got);
      ihpa_pkg::result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing expected (kind %0d)", got.kind));
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.data_byte !== want.data_byte)
        report($sformatf("data_byte 0x%0h, expected 0x%0h", got.data_byte, want.data_byte));
      if (got.word_address !== want.word_address)
        report($sformatf("word_address 0x%0h, expected 0x%0h",
                         got.word_address, want.word_address));
      if (got.page_bytes !== want.page_bytes)
        report($sformatf("page_bytes %0d, expected %0d", got.page_bytes, want.page_bytes));
      if (got.last !== want.last)
        report($sformatf("last %0b, expected %0b", got.last, want.last));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [7:0]  character    = 8'h00;
  logic        end_of_input = 1'b0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [30:0] word_address;
  logic [6:0]  page_bytes;
  logic        last;

  always #5 clk = ~clk;

  intel_hex_page_assembler dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .character    (character),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .data_byte    (data_byte),
    .word_address (word_address),
    .page_bytes   (page_bytes),
    .last         (last)
  );

  page_scoreboard sb = new();

  // Idling profile, changed per stimulus phase: percent chance of a gap
  // before an item (sender) or of a stall run starting (receiver).
  int unsigned in_idle_pct  = 0;
  int unsigned out_idle_pct = 0;
  int unsigned items_sent   = 0;
  int          stall_left   = 0;
  int          quiet        = 0;

  // Gap length, drawn from one of two ranges: mostly the lower, now and then the upper.
  function automatic int pick_gap();
    if ($urandom_range(9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] non_newline();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == ihpa_pkg::CHAR_LF);
    return c;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (page_scoreboard::digit_of(c) >= 0 || c == ihpa_pkg::CHAR_LF);
    return c;
  endfunction

  function automatic void push_hex(ref logic [7:0] text[$], input logic [15:0] v,
                                   input int digits, input bit lower);
    logic [3:0] d;
    for (int i = digits - 1; i >= 0; i--) begin
      d = v[4*i +: 4];
      if (d < 4'd10) text.push_back(8'(8'h30 + d));
      else text.push_back(8'((lower ? 8'h57 : 8'h37) + d));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stall runs. Stall only changes at the clock edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (out_idle_pct > 0 && $urandom_range(99) < out_idle_pct) begin
      stall_left = pick_gap() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result monitor. Values read right after the edge are the pre-edge ones,
  // since the block and the drivers only update through nonblocking writes.
  always @(posedge clk) begin
    ihpa_pkg::result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.kind         = ihpa_pkg::kind_t'(kind);
      got.data_byte    = data_byte;
      got.word_address = word_address;
      got.page_bytes   = page_bytes;
      got.last         = last;
      sb.check_result(got);
    end
  end

  // Watchdog: a hung handshake on either side ends the run.
  always @(posedge clk) begin
    if (rst) begin
      quiet = 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. One item per call: optional gap, then hold valid and payload until
  // an edge with stall low, where the item is taken and handed to the scoreboard.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [7:0] c, input logic eoi);
    int gap;
    if (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
      gap = pick_gap();
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    character    <= c;
    end_of_input <= eoi;
    do @(posedge clk); while (in_stall);
    sb.note_item(c, eoi);
    // carriage returns are dropped by the parser, so they do not count
    if (eoi || c != ihpa_pkg::CHAR_CR) items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // One line of text. Mostly well-formed records with random content; the
  // rest are broken records (cut short or with a stray character) and noise.
  task automatic send_random_line();
    logic [7:0]  text[$];
    int unsigned pick;
    int unsigned sel;
    int unsigned nbytes;
    int unsigned cut;
    logic [7:0]  rec;
    logic [15:0] offs;
    bit          lower;
    pick  = $urandom_range(99);
    lower = 1'($urandom_range(1));
    if (pick < 88) begin
      sel = $urandom_range(99);
      if (sel < 60) begin
        rec = ihpa_pkg::REC_DATA;
        // short records fill pages across record boundaries; a few long ones
        // span whole pages, the longest possible now and then
        if ($urandom_range(39) == 0)
          nbytes = ($urandom_range(3) == 0) ? 255 : $urandom_range(17, 80);
        else
          nbytes = $urandom_range(16);
      end else if (sel < 75) begin
        rec    = ihpa_pkg::REC_EXT_LIN;
        nbytes = ($urandom_range(3) == 0) ? $urandom_range(3) : 2;
      end else if (sel < 85) begin
        rec    = ihpa_pkg::REC_EOF;
        nbytes = ($urandom_range(3) == 0) ? $urandom_range(2) : 0;
      end else begin
        rec = 8'($urandom_range(255));
        if (rec == ihpa_pkg::REC_DATA || rec == ihpa_pkg::REC_EOF ||
            rec == ihpa_pkg::REC_EXT_LIN) rec = REC_EXT_SEG;
        nbytes = $urandom_range(4);
      end
      // a quarter of the offsets sit just below the 16-bit wrap
      if ($urandom_range(3) == 0) offs = 16'hFFF0 | 16'($urandom_range(15));
      else offs = 16'($urandom_range(16'hFFFF));

      text.push_back(ihpa_pkg::CHAR_COLON);
      push_hex(text, 16'(nbytes), 2, lower);
      push_hex(text, offs, 4, lower);
      push_hex(text, 16'(rec), 2, lower);
      repeat (nbytes) push_hex(text, 16'($urandom_range(255)), 2, lower);
      push_hex(text, 16'($urandom_range(255)), 2, lower);  // checksum, never checked
      if ($urandom_range(9) == 0) repeat ($urandom_range(1, 3)) text.push_back(non_newline());

      if (pick >= 70) begin
        cut = $urandom_range(text.size() - 1);
        if ($urandom_range(1)) begin
          while (text.size() > cut) void'(text.pop_back());
        end else begin
          text[cut] = non_hex_char();
        end
      end
    end else begin
      repeat ($urandom_range(5)) text.push_back(non_newline());
    end

    foreach (text[i]) send_item(text[i], 1'b0);
    if ($urandom_range(7) == 0) send_item(ihpa_pkg::CHAR_CR, 1'b0);
    // end of input sometimes cuts the line, sometimes follows a finished one
    if ($urandom_range(24) == 0) begin
      send_item(8'($urandom_range(255)), 1'b1);
    end else begin
      send_item(ihpa_pkg::CHAR_LF, 1'b0);
      if ($urandom_range(19) == 0) send_item(8'($urandom_range(255)), 1'b1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned goal;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed lines, no idling:
    //   empty line with a carriage return, line without a colon (extreme
    //   character values), bad hex digit in the length, line cut short,
    //   bare end-of-file record with no open page, end of input at line start.
    send_item(ihpa_pkg::CHAR_CR, 1'b0);
    send_item(ihpa_pkg::CHAR_LF, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_text("\n:0G\n:01\n:00000001\n");
    send_item(8'h00, 1'b1);

    // Random phases with different idling on each side. Between phases the
    // sender holds off until every expected result has come out.
    goal = items_sent;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin in_idle_pct = 0;  out_idle_pct = 0;  end
        1: begin in_idle_pct = 30; out_idle_pct = 0;  end
        2: begin in_idle_pct = 0;  out_idle_pct = 40; end
        3: begin in_idle_pct = 20; out_idle_pct = 20; end
        default: begin in_idle_pct = 50; out_idle_pct = 50; end
      endcase
      goal += TEXT_ITEMS / NUM_PHASES;
      while (items_sent < goal) send_random_line();
      in_valid <= 1'b0;
      do @(posedge clk); while (sb.expected_q.size() != 0);
    end

    // All results are in; wait DRAIN_CYCLES for stray results to show up.
    out_idle_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ihpa_pkg.sv
rtl/ihpa_parser.sv
rtl/ihpa_result_fifo.sv
rtl/intel_hex_page_assembler.sv
test/intel_hex_page_assembler_test.sv
